FILE: rtl/dftrh_pkg.sv
// Shared constants and types of the real-input half-spectrum DFT block.
// Used by the channel interfaces, the loader, the frame queue and the engine.
`timescale 1ns / 1ps
package dftrh_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_LENGTH_DEF        = 128;
  localparam int SAMPLE_WIDTH_DEF      = 16;
  localparam int TWIDDLE_FRAC_BITS_DEF = 15;

  // Fixed field widths of the channels.
  localparam int SAMPLE_IN_W = 16;
  localparam int CFG_W       = 3;
  localparam int BIN_INDEX_W = 6;
  localparam int BIN_SUM_W   = 39;

  // The twiddle circle always has 128 points, addressed by a 7-bit phase.
  localparam int TW_IDX_W = 7;

  localparam logic [CFG_W-1:0] LOG2_LENGTH_RST = 3'd7;

  // Two sample banks, so the queue of finished frames holds two entries.
  localparam int JOBQ_DEPTH = 2;

  // One loaded frame waiting to be transformed.
  typedef struct packed {
    logic             bank;
    logic [CFG_W-1:0] log2_len;
  } job_t;

endpackage

FILE: rtl/dftrh_if.sv
// Valid/ready channel interfaces of the DFT block: samples in, bins out,
// and the length register write channel. Depends on dftrh_pkg.
`timescale 1ns / 1ps
interface dftrh_sample_if;
  import dftrh_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_IN_W-1:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

interface dftrh_bin_if;
  import dftrh_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [BIN_INDEX_W-1:0]      bin_index;
  logic signed [BIN_SUM_W-1:0] bin_real;
  logic signed [BIN_SUM_W-1:0] bin_imag;
  logic                        last_bin;
  modport source (output valid, bin_index, bin_real, bin_imag, last_bin, input ready);
  modport sink (input valid, bin_index, bin_real, bin_imag, last_bin, output ready);
endinterface

interface dftrh_cfg_if;
  import dftrh_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] log2_length;
  modport source (output valid, log2_length, input ready);
  modport sink (input valid, log2_length, output ready);
endinterface

FILE: rtl/dftrh_front.sv
// Loader: holds the length register, accepts samples, writes them into the
// current bank and hands each completed frame to the queue. Uses dftrh_pkg.
`timescale 1ns / 1ps
module dftrh_front #(
  parameter int MAX_LENGTH   = dftrh_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_WIDTH = dftrh_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  dftrh_sample_if.sink                         sample_i,
  dftrh_cfg_if.sink                            cfg_i,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  output dftrh_pkg::job_t                      push_job_o,
  output logic                                 wr_en_o,
  output logic [$clog2(MAX_LENGTH):0]          wr_addr_o,
  output logic signed [SAMPLE_WIDTH-1:0]       wr_data_o
);
  import dftrh_pkg::*;

  localparam int IdxW   = $clog2(MAX_LENGTH);
  localparam int CntW   = $clog2(MAX_LENGTH + 1);
  localparam int CapRaw = $clog2(MAX_LENGTH + 1) - 1;
  localparam int LenCap = (CapRaw > TW_IDX_W) ? TW_IDX_W : CapRaw;

  logic [CFG_W-1:0] log2_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             bank_q;
  logic [CFG_W-1:0] len_eff;
  logic [CntW-1:0]  n_len;
  logic [CntW:0]    cnt_inc;
  logic             accept;
  logic             frame_done;

  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = !q_full_i;
  assign accept         = sample_i.valid && !q_full_i;

  // Clamp the register to the lengths the banks can hold; zero acts as one.
  always_comb begin
    if (log2_q == '0) begin
      len_eff = CFG_W'(1);
    end else if (log2_q > CFG_W'(LenCap)) begin
      len_eff = CFG_W'(LenCap);
    end else begin
      len_eff = log2_q;
    end
    n_len      = CntW'(1) << len_eff;
    cnt_inc    = {1'b0, cnt_q} + 1'b1;
    frame_done = cnt_inc >= {1'b0, n_len};
    cnt_d      = frame_done ? '0 : cnt_inc[CntW-1:0];
  end

  assign wr_en_o             = accept;
  assign wr_addr_o           = {bank_q, cnt_q[IdxW-1:0]};
  assign wr_data_o           = SAMPLE_WIDTH'(sample_i.sample);
  assign push_o              = accept && frame_done;
  assign push_job_o.bank     = bank_q;
  assign push_job_o.log2_len = len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q <= LOG2_LENGTH_RST;
      cnt_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        log2_q <= cfg_i.log2_length;
      end
      if (accept) begin
        cnt_q <= cnt_d;
        if (frame_done) begin
          bank_q <= !bank_q;
        end
      end
    end
  end

endmodule

FILE: rtl/dftrh_jobq.sv
// Short queue of loaded frames between the loader and the DFT engine.
// Depends on dftrh_pkg for the frame descriptor and the queue depth.
`timescale 1ns / 1ps
module dftrh_jobq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dftrh_pkg::job_t push_job_i,
  output logic            full_o,
  output logic            head_valid_o,
  output dftrh_pkg::job_t head_job_o,
  input  logic            pop_i
);
  import dftrh_pkg::*;

  localparam int PtrW = $clog2(JOBQ_DEPTH);

  job_t             entry_q [JOBQ_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q;

  assign full_o       = count_q == (PtrW + 1)'(JOBQ_DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_job_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/dftrh_back.sv
// DFT engine: two-bank sample memory, twiddle lookup, result register and
// one complex multiply-accumulate per cycle unless stalled. Uses dftrh_pkg.
`timescale 1ns / 1ps
module dftrh_back #(
  parameter int MAX_LENGTH        = dftrh_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_WIDTH      = dftrh_pkg::SAMPLE_WIDTH_DEF,
  parameter int TWIDDLE_FRAC_BITS = dftrh_pkg::TWIDDLE_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [$clog2(MAX_LENGTH):0]    wr_addr_i,
  input  logic signed [SAMPLE_WIDTH-1:0] wr_data_i,
  input  logic                           job_valid_i,
  input  dftrh_pkg::job_t                job_i,
  output logic                           pop_o,
  dftrh_bin_if.source                    bin_o
);
  import dftrh_pkg::*;

  localparam int IdxW = $clog2(MAX_LENGTH);
  localparam int KW   = (IdxW > 1) ? IdxW - 1 : 1;
  localparam int TwW  = TWIDDLE_FRAC_BITS + 1;
  localparam int PW   = SAMPLE_WIDTH + TwW;
  localparam int AccW = (PW + 8 > BIN_SUM_W + 1) ? PW + 8 : BIN_SUM_W + 1;

  // Quarter sine wave, Q1.17, at steps of pi/64.
  localparam logic [17:0] QSINE [33] = '{
    18'd0,      18'd6431,   18'd12847,  18'd19232,  18'd25571,  18'd31848,
    18'd38048,  18'd44157,  18'd50159,  18'd56041,  18'd61787,  18'd67384,
    18'd72820,  18'd78079,  18'd83151,  18'd88023,  18'd92682,  18'd97118,
    18'd101320, 18'd105278, 18'd108982, 18'd112424, 18'd115595, 18'd118488,
    18'd121095, 18'd123410, 18'd125428, 18'd127144, 18'd128553, 18'd129653,
    18'd130441, 18'd130914, 18'd131072
  };

  // Sine at phase m of 128, rounded half up and held below one.
  function automatic logic signed [TwW-1:0] rom_sine(input logic [TW_IDX_W-1:0] m);
    logic [1:0]       quad;
    logic [4:0]       r;
    logic [17:0]      v17;
    logic [18:0]      mag;
    logic signed [TwW-1:0] val;
    quad = m[6:5];
    r    = m[4:0];
    v17  = quad[0] ? QSINE[6'd32 - {1'b0, r}] : QSINE[r];
    mag  = ({1'b0, v17} + {1'b0, v17} + 19'(1 << (17 - TWIDDLE_FRAC_BITS)))
           >> (18 - TWIDDLE_FRAC_BITS);
    if (mag > 19'((1 << TWIDDLE_FRAC_BITS) - 1)) begin
      mag = 19'((1 << TWIDDLE_FRAC_BITS) - 1);
    end
    val = {1'b0, mag[TWIDDLE_FRAC_BITS-1:0]};
    return quad[1] ? -val : val;
  endfunction

  function automatic logic signed [BIN_SUM_W-1:0] sat_sum(input logic signed [AccW-1:0] s);
    logic [AccW-BIN_SUM_W:0] hi;
    hi = s[AccW-1:BIN_SUM_W-1];
    if ((&hi) || !(|hi)) begin
      return s[BIN_SUM_W-1:0];
    end
    return s[AccW-1] ? {1'b1, {(BIN_SUM_W-1){1'b0}}} : {1'b0, {(BIN_SUM_W-1){1'b1}}};
  endfunction

  logic signed [SAMPLE_WIDTH-1:0] mem [2*MAX_LENGTH];

  logic                  en;
  logic                  issue;
  logic [IdxW-1:0]       n_q;
  logic [KW-1:0]         k_q;
  logic [TW_IDX_W-1:0]   phase_q;
  logic [IdxW:0]         n_len;
  logic [IdxW-1:0]       n_max;
  logic [KW-1:0]         k_max;
  logic [TW_IDX_W-1:0]   step;
  logic                  last_n, last_k;

  // Stage 1: sample and twiddles read.
  logic                        v1_q, first1_q, last1_q, lastbin1_q;
  logic [KW-1:0]               k1_q;
  logic signed [SAMPLE_WIDTH-1:0] smp1_q;
  logic signed [TwW-1:0]       cos1_q, sin1_q;
  // Stage 2: products.
  logic                        v2_q, first2_q, last2_q, lastbin2_q;
  logic [KW-1:0]               k2_q;
  logic signed [PW-1:0]        pre_q, pim_q;
  // Stage 3: accumulators.
  logic signed [AccW-1:0]      acc_re_q, acc_im_q, sum_re, sum_im;

  logic                        out_valid_q;
  logic [BIN_INDEX_W-1:0]      out_index_q;
  logic signed [BIN_SUM_W-1:0] out_re_q, out_im_q;
  logic                        out_last_q;

  assign en    = !out_valid_q || bin_o.ready;
  assign issue = en && job_valid_i;

  always_comb begin
    n_len  = (IdxW + 1)'(1) << job_i.log2_len;
    n_max  = IdxW'(n_len - 1'b1);
    k_max  = KW'((n_len >> 1) - 1'b1);
    step   = TW_IDX_W'(k_q) << (3'(TW_IDX_W) - job_i.log2_len);
    last_n = n_q == n_max;
    last_k = k_q == k_max;
  end

  assign pop_o = issue && last_n && last_k;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (en) begin
      smp1_q <= mem[{job_i.bank, n_q}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      k_q     <= '0;
      phase_q <= '0;
    end else if (issue) begin
      if (last_n) begin
        n_q     <= '0;
        phase_q <= '0;
        k_q     <= last_k ? '0 : k_q + 1'b1;
      end else begin
        n_q     <= n_q + 1'b1;
        phase_q <= phase_q + step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= issue;
      v2_q        <= v1_q;
      out_valid_q <= v2_q && last2_q;
    end
  end

  always_comb begin
    sum_re = (first2_q ? AccW'(0) : acc_re_q) + AccW'(pre_q);
    sum_im = (first2_q ? AccW'(0) : acc_im_q) - AccW'(pim_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      first1_q   <= n_q == '0;
      last1_q    <= last_n;
      lastbin1_q <= last_k;
      k1_q       <= k_q;
      cos1_q     <= rom_sine(phase_q + TW_IDX_W'(32));
      sin1_q     <= rom_sine(phase_q);
      first2_q   <= first1_q;
      last2_q    <= last1_q;
      lastbin2_q <= lastbin1_q;
      k2_q       <= k1_q;
      pre_q      <= smp1_q * cos1_q;
      pim_q      <= smp1_q * sin1_q;
      if (v2_q) begin
        acc_re_q <= sum_re;
        acc_im_q <= sum_im;
        if (last2_q) begin
          out_index_q <= BIN_INDEX_W'(k2_q);
          out_re_q    <= sat_sum(sum_re);
          out_im_q    <= sat_sum(sum_im);
          out_last_q  <= lastbin2_q;
        end
      end
    end
  end

  assign bin_o.valid     = out_valid_q;
  assign bin_o.bin_index = out_index_q;
  assign bin_o.bin_real  = out_re_q;
  assign bin_o.bin_imag  = out_im_q;
  assign bin_o.last_bin  = out_last_q;

endmodule

FILE: rtl/real_input_dft_half_spectrum.sv
// Top level of the real-input half-spectrum DFT: loader, frame queue and
// DFT engine. Depends on dftrh_pkg and the channel interfaces in dftrh_if.sv.
//
// Usage. Real samples arrive one request at a time on sample_i. The length
// register, written through cfg_i (always ready), sets N = 2^log2_length;
// values below one act as one and values above the bank size are clamped.
// Once N samples have been accepted the frame is complete, and bins
// k = 0 .. N/2-1 of its direct DFT leave on bin_o in order, each with the
// real sum and the negative-sine imaginary sum at 15 fractional bits and
// last_bin set on the final bin of the frame.
//
// Timing. The engine does one complex multiply-accumulate per cycle while
// a frame is queued and bin_o is not stalled: one product for each sample
// and each bin of the frame. Each bin passes the sample and twiddle read,
// the products and the accumulators before the result register holds it.
// Samples are written into one of two banks, so the next frame loads while
// the current one is being transformed; sample_i stalls only when both
// banks hold unfinished frames.
//
// Reset clears the load count, queue and pipeline and sets the length
// register to 7 (N = 128). When bin_o stalls, the whole engine pipeline
// holds and the result register keeps its bin until the request is taken.
`timescale 1ns / 1ps
module real_input_dft_half_spectrum #(
  parameter int MAX_LENGTH        = dftrh_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_WIDTH      = dftrh_pkg::SAMPLE_WIDTH_DEF,
  parameter int TWIDDLE_FRAC_BITS = dftrh_pkg::TWIDDLE_FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dftrh_sample_if.sink sample_i,
  dftrh_cfg_if.sink    cfg_i,
  dftrh_bin_if.source  bin_o
);
  import dftrh_pkg::*;

  localparam int IdxW = $clog2(MAX_LENGTH);

  // Write port from the loader into the engine's sample memory.
  logic                           wr_en;
  logic [IdxW:0]                  wr_addr;
  logic signed [SAMPLE_WIDTH-1:0] wr_data;

  // Frame hand-off through the queue.
  logic push, q_full, head_valid, pop;
  job_t push_job, head_job;

  dftrh_front #(
    .MAX_LENGTH  (MAX_LENGTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_i),
    .cfg_i     (cfg_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .push_job_o(push_job),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  dftrh_jobq u_jobq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .full_o      (q_full),
    .head_valid_o(head_valid),
    .head_job_o  (head_job),
    .pop_i       (pop)
  );

  // The engine releases a bank as soon as its last sample has been read.
  dftrh_back #(
    .MAX_LENGTH       (MAX_LENGTH),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .TWIDDLE_FRAC_BITS(TWIDDLE_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .job_valid_i(head_valid),
    .job_i      (head_job),
    .pop_o      (pop),
    .bin_o      (bin_o)
  );

endmodule
